>>> rtl/multi_channel_led_fade_engine_top_assert.svh
// ----------------------------------------------------------------------------
// multi_channel_led_fade_engine_top_assert
// Assertion macros for the fade engine top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_LED_FADE_ENGINE_TOP_ASSERT_SVH
`define MULTI_CHANNEL_LED_FADE_ENGINE_TOP_ASSERT_SVH
// Property that holds on every clock edge outside reset.
`define MCLF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on the next edge.
`define MCLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/mclf_pkg.sv
// ----------------------------------------------------------------------------
// mclf_pkg
// Shared types, constants and command codes of the LED fade engine.
// ----------------------------------------------------------------------------
package mclf_pkg;
  localparam int unsigned NumChannels = 4;
  localparam int unsigned LevelBits   = 12;
  localparam int unsigned TimeBits    = 32;
  localparam int unsigned UsPerMs     = 1000;
  localparam int unsigned IvBits      = 27;
  localparam int unsigned RangeBits   = 17;

  localparam logic [2:0]  PresetReset  = 3'd4;
  localparam logic [15:0] OffFadeReset = 16'd500;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_FADE_FROM = 3'd1,
    CMD_FADE_CUR  = 3'd2,
    CMD_ZONES     = 3'd3,
    CMD_ALL_OFF   = 3'd4
  } cmd_e;

  localparam logic CFG_PRESET   = 1'b0;
  localparam logic CFG_OFF_FADE = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  channel;
    logic [11:0] start_level;
    logic [11:0] target_level;
    logic [15:0] ramp_ms;
    logic [11:0] step_amt;
    logic [3:0]  zone_mask;
  } item_t;

  typedef struct packed {
    logic [47:0] levels;
    logic [3:0]  active_mask;
    logic        all_dark;
    logic [31:0] dark_since;
  } result_t;
endpackage

>>> rtl/mclf_div.sv
// ----------------------------------------------------------------------------
// mclf_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mclf_div #(
  parameter int unsigned NBits = 27,
  parameter int unsigned DBits = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NBits-1:0] num_i,
  input  logic [DBits-1:0] den_i,
  output logic             done_o,
  output logic [NBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(NBits + 1);

  logic [NBits-1:0]   quot_q, quot_d;
  logic [DBits:0]     rem_q, rem_d;
  logic [DBits-1:0]   den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DBits:0]     trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DBits-1:0], quot_q[NBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NBits-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

>>> rtl/mclf_front.sv
// ----------------------------------------------------------------------------
// mclf_front
// Input queue of two words between the port and the execution engine.
// ----------------------------------------------------------------------------
module mclf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  mclf_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            take_i,
  output mclf_pkg::item_t item_o
);
  import mclf_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign wr      = push_i && !full_o;
  assign rd      = take_i && valid_o;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= item_i;
  end
endmodule

>>> rtl/mclf_back.sv
// ----------------------------------------------------------------------------
// mclf_back
// Sequencer that carries out one command at a time, channel by channel.
// ----------------------------------------------------------------------------
module mclf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              take_o,
  input  mclf_pkg::item_t   item_i,
  input  logic [2:0]        preset_i,
  input  logic [15:0]       off_fade_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output mclf_pkg::result_t res_o
);
  import mclf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHAN, S_DIV1, S_DIV2, S_DARK, S_OUT
  } state_e;

  state_e      state_q;
  item_t       it_q;
  logic [1:0]  ch_q;
  logic [11:0] level_q [4];
  logic [11:0] target_q [4];
  logic        up_q [4];
  logic [11:0] step_q [4];
  logic [IvBits-1:0] iv_q [4];
  logic [31:0] last_q [4];
  logic [3:0]  run_q, occ_q, forced_q;
  logic [31:0] now_q, dark_time_q;
  logic        was_dark_q;
  logic        res_valid_q;
  result_t     res_q;

  // Fade set-up operands held across the divisions.
  logic [15:0]          f_dur_q;
  logic                 f_last_q;

  // Combinational fade set-up.
  logic [11:0] s_start, s_end, s_step;
  logic [15:0] s_dur;
  logic [2:0]  s_pre;
  logic [13:0] scaled;
  logic        s_do, s_first;
  logic [11:0] range;
  logic [11:0] eff_tgt;

  logic               div_start, div_done;
  logic [IvBits-1:0]  div_num, div_q;
  logic [RangeBits-1:0] div_den;

  mclf_div #(.NBits(IvBits), .DBits(RangeBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q)
  );

  logic [12:0] v_sum;
  logic [12:0] v_dif;
  logic [3:0]  levels_nz;
  logic [47:0] lv_pack;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      levels_nz[i] = level_q[i] != '0;
      lv_pack[i*12 +: 12] = level_q[i];
    end
  end

  // On a tick an unoccupied channel heads for zero, even in mid-fade.
  assign eff_tgt = (it_q.cmd == CMD_TICK && !occ_q[ch_q]) ? '0 : target_q[ch_q];

  assign take_o = state_q == S_IDLE && valid_i && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      it_q        <= '0;
      f_dur_q     <= '0;
      f_last_q    <= 1'b0;
      ch_q        <= '0;
      run_q       <= '0;
      occ_q       <= '1;
      forced_q    <= '0;
      now_q       <= '0;
      dark_time_q <= '0;
      was_dark_q  <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        level_q[i]  <= '0;
        target_q[i] <= '0;
        up_q[i]     <= 1'b0;
        step_q[i]   <= '0;
        iv_q[i]     <= '0;
        last_q[i]   <= '0;
      end
    end else begin
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take_o) begin
            it_q <= item_i;
            ch_q <= (item_i.cmd == CMD_TICK || item_i.cmd == CMD_ALL_OFF)
                    ? 2'd0 : item_i.channel;
            if (item_i.cmd == CMD_TICK) now_q <= now_q + 1'b1;
            if (item_i.cmd == CMD_ZONES) occ_q <= item_i.zone_mask;
            state_q <= (item_i.cmd == CMD_TICK || item_i.cmd == CMD_FADE_FROM ||
                        item_i.cmd == CMD_FADE_CUR || item_i.cmd == CMD_ALL_OFF)
                       ? S_CHAN : S_OUT;
          end
        end
        S_CHAN: begin
          f_last_q <= it_q.cmd == CMD_FADE_FROM || it_q.cmd == CMD_FADE_CUR
                      || ch_q == 2'd3;
          if (it_q.cmd == CMD_TICK) forced_q[ch_q] <= !occ_q[ch_q];
          if (s_do) begin
            if (s_first) begin
              level_q[ch_q]  <= s_end;
              target_q[ch_q] <= s_end;
              run_q[ch_q]    <= 1'b0;
              state_q        <= S_DARK;
            end else begin
              run_q[ch_q]    <= 1'b1;
              level_q[ch_q]  <= s_start;
              target_q[ch_q] <= s_end;
              up_q[ch_q]     <= s_end > s_start;
              step_q[ch_q]   <= s_step;
              last_q[ch_q]   <= now_q;
              f_dur_q <= s_dur;
              state_q <= S_DIV1;
            end
          end else begin
            if (it_q.cmd == CMD_TICK && !occ_q[ch_q]) target_q[ch_q] <= '0;
            if (it_q.cmd == CMD_TICK && run_q[ch_q] &&
                (now_q - last_q[ch_q]) >= {5'd0, iv_q[ch_q]}) begin
              // One step of a running fade, clamped at its target.
              last_q[ch_q] <= now_q;
              if (up_q[ch_q] ? (v_sum >= {1'b0, eff_tgt})
                             : (v_dif[12] || v_dif <= {1'b0, eff_tgt})) begin
                level_q[ch_q] <= eff_tgt;
                run_q[ch_q]   <= 1'b0;
              end else begin
                level_q[ch_q] <= up_q[ch_q] ? v_sum[11:0] : v_dif[11:0];
              end
            end
            state_q <= S_DARK;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            state_q <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            iv_q[ch_q] <= (div_q == '0) ? IvBits'(1) : div_q;
            state_q <= S_DARK;
          end
        end
        S_DARK: begin
          if (f_last_q) begin
            if (it_q.cmd == CMD_TICK) begin
              was_dark_q <= (run_q == '0) && (levels_nz == '0);
              if ((run_q == '0) && (levels_nz == '0) && !was_dark_q)
                dark_time_q <= now_q;
            end
            state_q <= S_OUT;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_CHAN;
          end
        end
        S_OUT: begin
          if (!res_valid_q) begin
            res_valid_q       <= 1'b1;
            res_q.levels      <= lv_pack;
            res_q.active_mask <= run_q;
            res_q.all_dark    <= was_dark_q;
            res_q.dark_since  <= dark_time_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign v_sum = {1'b0, level_q[ch_q]} + {1'b0, step_q[ch_q]};
  assign v_dif = {1'b0, level_q[ch_q]} - {1'b0, step_q[ch_q]};

  // Fade request of the channel in hand, if any.
  always_comb begin
    s_do    = 1'b0;
    s_start = level_q[ch_q];
    s_end   = '0;
    s_dur   = off_fade_i;
    s_step  = 12'd1;
    case (it_q.cmd)
      CMD_TICK: s_do = !occ_q[ch_q] && !run_q[ch_q] && levels_nz[ch_q];
      CMD_ALL_OFF: s_do = 1'b1;
      CMD_FADE_FROM, CMD_FADE_CUR: begin
        s_end  = it_q.target_level;
        s_dur  = it_q.ramp_ms;
        s_step = (it_q.step_amt == '0) ? 12'd1 : it_q.step_amt;
        if (it_q.cmd == CMD_FADE_FROM) s_start = it_q.start_level;
        s_do = !(forced_q[ch_q] && it_q.target_level != '0);
      end
      default: s_do = 1'b0;
    endcase
    // Fade commands scale their target by the preset in quarters; the fades of a tick or all-off aim at zero, unscaled.
    s_pre  = (it_q.cmd == CMD_FADE_FROM || it_q.cmd == CMD_FADE_CUR) ? preset_i : 3'd4;
    scaled = 14'(s_end) * 14'(s_pre);
    s_end  = scaled[13:2];
    s_first = (s_start == s_end) || (s_dur == '0);
  end

  assign range = (s_end > s_start) ? s_end - s_start : s_start - s_end;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_q == S_CHAN && s_do && !s_first) begin
      div_start = 1'b1;
      div_num   = IvBits'(range);
      div_den   = RangeBits'(s_step);
    end else if (state_q == S_DIV1 && div_done) begin
      div_start = 1'b1;
      div_num   = IvBits'(f_dur_q) * IvBits'(UsPerMs);
      div_den   = (div_q == '0) ? RangeBits'(1) : RangeBits'(div_q);
    end
  end
endmodule

>>> rtl/multi_channel_led_fade_engine_top.sv
// ----------------------------------------------------------------------------
// multi_channel_led_fade_engine_top
// Four-channel LED fade engine with queue-style command and result ports.
// ----------------------------------------------------------------------------
// Commands enter through push/full into a two-word queue; results leave
// through empty/pop. Every command gives exactly one result word holding
// all channel levels, the active mask, the dark flag and its time stamp.
// A zone or unknown command goes straight to its result; a fade that
// sets the level at once passes through its channel and the dark check,
// and a tick or all-off command walks all four channels in turn.
// Each channel that starts a ramp adds two serial divisions.
// The engine takes the next word in the cycle after its result has been
// popped, and takes no new word while a result waits to be popped.
// A stalled receiver holds the engine while the input queue still takes
// two further words.
// Reset clears all levels, sets every zone occupied, preset 4 and an
// off-fade time of 500 ms. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module multi_channel_led_fade_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cmd_i,
  input  logic [1:0]  channel_i,
  input  logic [11:0] start_level_i,
  input  logic [11:0] target_level_i,
  input  logic [15:0] ramp_ms_i,
  input  logic [11:0] step_amt_i,
  input  logic [3:0]  zone_mask_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] level_ch0_o,
  output logic [11:0] level_ch1_o,
  output logic [11:0] level_ch2_o,
  output logic [11:0] level_ch3_o,
  output logic [3:0]  active_mask_o,
  output logic        all_dark_o,
  output logic [31:0] dark_since_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import mclf_pkg::*;

  item_t      in_item, q_item;
  result_t    res;
  logic       q_valid, q_take, res_valid;
  logic [2:0] preset_q;
  logic [15:0] off_fade_q;

  assign in_item = '{cmd: cmd_i, channel: channel_i, start_level: start_level_i,
                     target_level: target_level_i, ramp_ms: ramp_ms_i,
                     step_amt: step_amt_i, zone_mask: zone_mask_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q   <= PresetReset;
      off_fade_q <= OffFadeReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PRESET) begin
        if (cfg_wdata_i[2:0] >= 3'd1 && cfg_wdata_i[2:0] <= 3'd4)
          preset_q <= cfg_wdata_i[2:0];
      end else begin
        off_fade_q <= cfg_wdata_i;
      end
    end
  end

  mclf_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .valid_o(q_valid), .take_i(q_take), .item_o(q_item)
  );

  mclf_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .take_o(q_take), .item_i(q_item),
    .preset_i(preset_q), .off_fade_i(off_fade_q), .res_valid_o(res_valid),
    .res_ready_i(pop), .res_o(res)
  );

  assign empty         = !res_valid;
  assign level_ch0_o   = res.levels[11:0];
  assign level_ch1_o   = res.levels[23:12];
  assign level_ch2_o   = res.levels[35:24];
  assign level_ch3_o   = res.levels[47:36];
  assign active_mask_o = res.active_mask;
  assign all_dark_o    = res.all_dark;
  assign dark_since_o  = res.dark_since;

`include "multi_channel_led_fade_engine_top_assert.svh"

  `MCLF_ASSERT(a_preset_range, preset_q >= 3'd1 && preset_q <= 3'd4, "preset out of range")
  `MCLF_ASSERT_NEXT(a_word_stable, !empty && !pop, $stable(level_ch0_o) && $stable(active_mask_o) && $stable(dark_since_o), "result word changed while stalled")
  `MCLF_ASSERT_NEXT(a_hold, !empty && !pop, !empty, "result lost while stalled")
endmodule
